// File: rtl/vts_pkg.sv
// Package for the versioned transactional store core.
// Holds sizes and the operation codes.
package vts_pkg;
    localparam int CELLS = 128;
    localparam int CONTEXTS = 8;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS = $clog2(CELLS);
    localparam int CTX_BITS = $clog2(CONTEXTS);
    localparam int VER_BITS = 32;
    localparam logic [VER_BITS-1:0] CLOCK_MAX = '1;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_COMMIT = 2'd3
    } op_t;
endpackage

// File: rtl/versioned_transactional_store_core.sv
// Versioned transactional store: start, read, write and commit of transactions.
// Start, read and write pass through the access and reply states; a passing commit walks
// all cells to validate, one cell per cycle, then to publish, one per cycle. A stale read
// ends a commit's validate walk early; a clock at its maximum aborts it with no walk.
// Throughput: one item at a time, busy is high until the result strobe. Reset clears
// marks, valid bits and snapshots and sets the clock to one; cell data and versions are
// not cleared; a per-cell valid bit makes unwritten cells read zero data and version zero.
module versioned_transactional_store_core
    import vts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [2:0]         ctx,
    input  logic [6:0]         index,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] data,
    output logic               aborted
);
    typedef enum logic [2:0] {
        S_IDLE, S_ACCESS, S_VALIDATE, S_PUBLISH, S_REPLY
    } state_t;

    // stores
    logic [DATA_BITS-1:0] cell_data_mem [CELLS];
    logic [VER_BITS-1:0]  cell_version_mem [CELLS];
    logic [CELLS-1:0]     cell_valid_reg;
    logic [DATA_BITS-1:0] redo_mem [CONTEXTS*CELLS];
    logic [CELLS-1:0]     read_marks_reg [CONTEXTS];
    logic [CELLS-1:0]     write_marks_reg [CONTEXTS];
    logic [VER_BITS-1:0]  snapshot_reg [CONTEXTS];
    logic [VER_BITS-1:0]  clock_reg;

    state_t               state_reg;
    op_t                  op_reg;
    logic [CTX_BITS-1:0]  ctx_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic                 ctx_ok_reg;
    logic [IDX_BITS:0]    walk_reg;
    logic signed [31:0]   data_reg;
    logic                 aborted_reg;
    logic                 done_reg;
    logic signed [31:0]   value_reg;

    // registered memory read data
    logic [DATA_BITS-1:0] cd_q, rb_q;
    logic [VER_BITS-1:0]  cv_q;
    logic                 cvalid_q;

    logic [IDX_BITS-1:0]  rd_idx;
    logic [IDX_BITS-1:0]  walk_idx;
    logic                 walk_last;

    assign walk_idx  = walk_reg[IDX_BITS-1:0];
    assign walk_last = (walk_reg == (IDX_BITS+1)'(CELLS - 1));

    // read address: incoming index on accept, one ahead of the walk while walking
    always_comb
    begin
        if (state_reg == S_IDLE)
            rd_idx = index[IDX_BITS-1:0];
        else if (state_reg == S_VALIDATE || state_reg == S_PUBLISH)
            rd_idx = walk_idx + IDX_BITS'(1);
        else
            rd_idx = walk_idx;
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        cd_q <= cell_data_mem[rd_idx];
        cv_q <= cell_version_mem[rd_idx];
        rb_q <= redo_mem[{(state_reg == S_IDLE) ? ctx[CTX_BITS-1:0] : ctx_reg, rd_idx}];
        if (state_reg == S_ACCESS && op_reg == OP_WRITE && ctx_ok_reg)
            redo_mem[{ctx_reg, idx_reg}] <= value_reg[DATA_BITS-1:0];
        if (state_reg == S_PUBLISH && write_marks_reg[ctx_reg][walk_idx])
        begin
            cell_data_mem[walk_idx]    <= rb_q;
            cell_version_mem[walk_idx] <= clock_reg;
        end
    end

    always_ff @(posedge clk)
        if (start && !busy)
            value_reg <= value;

    function automatic logic signed [31:0] to_out(input logic [DATA_BITS-1:0] v);
        return 32'(signed'(v));
    endfunction

    logic [VER_BITS-1:0] ver_eff;
    assign ver_eff = cvalid_q ? cv_q : '0;

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_reg      <= VER_BITS'(1);
            cell_valid_reg <= '0;
            for (int c = 0; c < CONTEXTS; c++)
            begin
                read_marks_reg[c]  <= '0;
                write_marks_reg[c] <= '0;
                snapshot_reg[c]    <= '0;
            end
            done_reg    <= 1'b0;
            data_reg    <= '0;
            aborted_reg <= 1'b0;
            walk_reg    <= '0;
            cvalid_q    <= 1'b0;
            op_reg      <= OP_START;
            ctx_reg     <= '0;
            idx_reg     <= '0;
            ctx_ok_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            cvalid_q <= cell_valid_reg[rd_idx];
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= op_t'(op);
                        ctx_reg    <= ctx[CTX_BITS-1:0];
                        idx_reg    <= index[IDX_BITS-1:0];
                        ctx_ok_reg <= (32'(ctx) < CONTEXTS);
                        walk_reg   <= '0;
                        state_reg  <= S_ACCESS;
                    end
                end
                S_ACCESS:
                begin
                    data_reg    <= '0;
                    aborted_reg <= 1'b0;
                    state_reg   <= S_REPLY;
                    if (ctx_ok_reg)
                    begin
                        case (op_reg)
                            OP_START:
                            begin
                                read_marks_reg[ctx_reg]  <= '0;
                                write_marks_reg[ctx_reg] <= '0;
                                snapshot_reg[ctx_reg]    <= clock_reg;
                            end
                            OP_READ:
                            begin
                                if (write_marks_reg[ctx_reg][idx_reg])
                                    data_reg <= to_out(rb_q);
                                else
                                begin
                                    read_marks_reg[ctx_reg][idx_reg] <= 1'b1;
                                    if (ver_eff >= snapshot_reg[ctx_reg])
                                        aborted_reg <= 1'b1;
                                    else
                                        data_reg <= cvalid_q ? to_out(cd_q) : '0;
                                end
                            end
                            OP_WRITE:
                                write_marks_reg[ctx_reg][idx_reg] <= 1'b1;
                            OP_COMMIT:
                            begin
                                if (clock_reg == CLOCK_MAX)
                                    aborted_reg <= 1'b1;
                                else
                                    state_reg <= S_VALIDATE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_VALIDATE:
                begin
                    // cell at walk position is in cv_q; abort on a stale read
                    if (read_marks_reg[ctx_reg][walk_idx]
                        && ver_eff >= snapshot_reg[ctx_reg])
                    begin
                        aborted_reg <= 1'b1;
                        state_reg   <= S_REPLY;
                    end
                    else if (walk_last)
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_PUBLISH;
                    end
                    else
                        walk_reg <= walk_reg + (IDX_BITS+1)'(1);
                end
                S_PUBLISH:
                begin
                    // rb_q for the walk position was fetched in the previous cycle
                    if (write_marks_reg[ctx_reg][walk_idx])
                        cell_valid_reg[walk_idx] <= 1'b1;
                    if (walk_last)
                    begin
                        clock_reg <= clock_reg + VER_BITS'(1);
                        state_reg <= S_REPLY;
                    end
                    else
                        walk_reg <= walk_reg + (IDX_BITS+1)'(1);
                end
                S_REPLY:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign data    = data_reg;
    assign aborted = aborted_reg;

    // checks
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !aborted || data == 0) else $error("abort with data");
    a_clock_nz: assert property (@(posedge clk) disable iff (!rst_n)
        clock_reg != 0) else $error("clock wrapped");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("double strobe");
endmodule
